### hw/rtl/rbsi_pkg.sv
`timescale 1ns / 1ps

package rbsi_pkg;

   localparam int unsigned COORD_W  = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned DIFF_W   = COORD_W + 1;
   localparam int unsigned PROD_W   = 2 * COORD_W;
   localparam int unsigned AXES     = 3;
   localparam int unsigned REQ_DW   = 12 * COORD_W;
   localparam int unsigned RSP_DW   = 40;

   localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;

   // stage load strobes shared by the axis lanes
   typedef struct packed {
      logic load_mul;
      logic load_sat;
   } pipe_ctrl_type;

endpackage

### hw/rtl/rbsi_slab_axis.sv
`timescale 1ns / 1ps

module rbsi_slab_axis
   import rbsi_pkg::*;
(
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  coord_type     origin,
   input  coord_type     inv_dir,
   input  coord_type     box_min,
   input  coord_type     box_max,
   output coord_type     t_lo,
   output coord_type     t_hi
);

   logic signed [DIFF_W-1:0]   diff_min;
   logic signed [DIFF_W-1:0]   diff_max;
   logic signed [PROD_W-1:0]   prod_min_full;
   logic signed [PROD_W-1:0]   prod_max_full;
   logic signed [PROD_W-1:0]   prod_min_ff;
   logic signed [PROD_W-1:0]   prod_max_ff;
   logic signed [PROD_W-1:0]   prod_min_in;
   logic signed [PROD_W-1:0]   prod_max_in;
   coord_type                  t0;
   coord_type                  t1;
   coord_type                  t_lo_ff;
   coord_type                  t_hi_ff;
   coord_type                  t_lo_in;
   coord_type                  t_hi_in;

   function automatic coord_type rescale_sat(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-FRAC_W-1:0] sh;
      coord_type                       res;
      sh = prod[PROD_W-1:FRAC_W];
      if (&sh[PROD_W-FRAC_W-1:COORD_W-1] || ~|sh[PROD_W-FRAC_W-1:COORD_W-1]) begin
         res = sh[COORD_W-1:0];
      end else if (sh[PROD_W-FRAC_W-1]) begin
         res = T_MIN;
      end else begin
         res = T_MAX;
      end
      return res;
   endfunction

   assign diff_min = DIFF_W'(box_min) - DIFF_W'(origin);
   assign diff_max = DIFF_W'(box_max) - DIFF_W'(origin);
   assign prod_min_full = PROD_W'(diff_min) * PROD_W'(inv_dir);
   assign prod_max_full = PROD_W'(diff_max) * PROD_W'(inv_dir);
   assign prod_min_in = ctrl.load_mul ? prod_min_full : prod_min_ff;
   assign prod_max_in = ctrl.load_mul ? prod_max_full : prod_max_ff;

   assign t0 = rescale_sat(prod_min_ff);
   assign t1 = rescale_sat(prod_max_ff);
   assign t_lo_in = ctrl.load_sat ? ((t0 < t1) ? t0 : t1) : t_lo_ff;
   assign t_hi_in = ctrl.load_sat ? ((t0 < t1) ? t1 : t0) : t_hi_ff;

   always_ff @(posedge clock) begin
      prod_min_ff <= prod_min_in;
      prod_max_ff <= prod_max_in;
      t_lo_ff     <= t_lo_in;
      t_hi_ff     <= t_hi_in;
   end

   assign t_lo = t_lo_ff;
   assign t_hi = t_hi_ff;

endmodule

### hw/rtl/ray_box_slab_intersect_core.sv
`timescale 1ns / 1ps

// Ray versus axis-aligned box test by the slab method. One beat per cycle in and out while
// responses are taken, passing from an accepted request to its response through the input
// register, six 33x32 slab multipliers, rescale/saturate with the per-axis sort, then the
// near/far reduction, hit decision and clamp into the output register. Each stage holds its
// beat and the next one moves up whenever the stage ahead is empty or draining, so a stalled
// response only backs up the pipeline once all stages are full. A missed box reports t_near
// as zero; while clamp_inside is set (as after reset), negative hit entry distances are zeroed too.
module ray_box_slab_intersect_core
   import rbsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_wdata,   // clamp_inside
   input  logic              req_tvalid,
   output logic              req_tready,
   // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z (32 bits each)
   input  logic [REQ_DW-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // hit [0], t_near [32:1], zero fill [39:33]
   output logic [RSP_DW-1:0] rsp_tdata
);

   logic              clamp_ff;
   logic              clamp_in;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              v1_in, v2_in, v3_in, v4_in;
   logic              load1, load2, load3, load4;
   logic [REQ_DW-1:0] req_ff;
   logic [REQ_DW-1:0] req_in;
   pipe_ctrl_type     ctrl;
   coord_type         t_lo [AXES];
   coord_type         t_hi [AXES];
   coord_type         near_xy, near_all;
   coord_type         far_xy, far_all;
   logic              hit;
   coord_type         t_near;
   logic              hit_ff, hit_in;
   coord_type         t_near_ff, t_near_in;

   assign load4 = !v4_ff || rsp_tready;
   assign load3 = !v3_ff || load4;
   assign load2 = !v2_ff || load3;
   assign load1 = !v1_ff || load2;
   assign req_tready = load1;

   assign v1_in = load1 ? req_tvalid : v1_ff;
   assign v2_in = load2 ? v1_ff : v2_ff;
   assign v3_in = load3 ? v2_ff : v3_ff;
   assign v4_in = load4 ? v3_ff : v4_ff;
   assign clamp_in = csr_we ? csr_wdata : clamp_ff;
   assign req_in = load1 ? req_tdata : req_ff;

   assign ctrl.load_mul = load2;
   assign ctrl.load_sat = load3;

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      rbsi_slab_axis u_axis (
         .clock   (clock),
         .ctrl    (ctrl),
         .origin  (req_ff[a*COORD_W +: COORD_W]),
         .inv_dir (req_ff[(AXES+a)*COORD_W +: COORD_W]),
         .box_min (req_ff[(2*AXES+a)*COORD_W +: COORD_W]),
         .box_max (req_ff[(3*AXES+a)*COORD_W +: COORD_W]),
         .t_lo    (t_lo[a]),
         .t_hi    (t_hi[a])
      );
   end

   assign near_xy  = (t_lo[1] > t_lo[0]) ? t_lo[1] : t_lo[0];
   assign near_all = (t_lo[2] > near_xy) ? t_lo[2] : near_xy;
   assign far_xy   = (t_hi[1] < t_hi[0]) ? t_hi[1] : t_hi[0];
   assign far_all  = (t_hi[2] < far_xy) ? t_hi[2] : far_xy;
   assign hit      = (far_all >= near_all) && !far_all[COORD_W-1];
   assign t_near   = (!hit || (clamp_ff && near_all[COORD_W-1])) ? '0 : near_all;

   assign hit_in    = load4 ? hit : hit_ff;
   assign t_near_in = load4 ? t_near : t_near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= 1'b1;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         clamp_ff <= clamp_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      hit_ff    <= hit_in;
      t_near_ff <= t_near_in;
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {(RSP_DW-COORD_W-1)'(0), t_near_ff, hit_ff};

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import rbsi_pkg::*;

   localparam coord_type Q_ONE          = 32'sd65536;
   localparam int        WATCHDOG_LIMIT = 4000;
   localparam int        MAX_REPORTS    = 10;
   localparam int        LONG_HOLD      = 400;
   localparam int        SETTLE_CYCLES  = 8;

   typedef struct {
      coord_type org[AXES];
      coord_type inv[AXES];
      coord_type lo[AXES];
      coord_type hi[AXES];
   } ray_type;

   typedef struct {
      logic      hit;
      coord_type t_near;
   } verdict_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_we     = 1'b0;
   logic              csr_wdata  = 1'b0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;

   logic        clamp_model   = 1'b1;
   verdict_type verdict_q[$];
   int          mismatches    = 0;
   int          burst_left    = 0;
   int          max_gap       = 5;
   int          hold_requests = 0;
   int          holds_served  = 0;
   int          hold_left     = 0;
   int          rx_run_left   = 0;
   logic        rx_ready_run  = 1'b0;
   int          quiet_cycles  = 0;

   ray_box_slab_intersect_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic coord_type slab_distance(coord_type corner, coord_type org,
                                                coord_type inv);
      longint prod;
      longint q;
      prod = (longint'(corner) - longint'(org)) * longint'(inv);
      q = prod >>> FRAC_W;
      if (q > longint'(T_MAX)) return T_MAX;
      if (q < longint'(T_MIN)) return T_MIN;
      return coord_type'(q);
   endfunction

   function automatic verdict_type predict_verdict(ray_type r, logic clamp);
      verdict_type v;
      coord_type   t0;
      coord_type   t1;
      coord_type   t_entry;
      coord_type   t_exit;
      t_entry = T_MIN;
      t_exit  = T_MAX;
      for (int a = 0; a < AXES; a++) begin
         t0 = slab_distance(r.lo[a], r.org[a], r.inv[a]);
         t1 = slab_distance(r.hi[a], r.org[a], r.inv[a]);
         if (t1 < t0) begin
            t0 = t1;
            t1 = slab_distance(r.lo[a], r.org[a], r.inv[a]);
         end
         if (t0 > t_entry) t_entry = t0;
         if (t1 < t_exit) t_exit = t1;
      end
      v.hit    = (t_exit >= t_entry) && (t_exit >= 0);
      v.t_near = (!v.hit || (clamp && t_entry < 0)) ? coord_type'(0) : t_entry;
      return v;
   endfunction

   function automatic logic [REQ_DW-1:0] pack_ray(ray_type r);
      logic [REQ_DW-1:0] d;
      d = '0;
      for (int a = 0; a < AXES; a++) begin
         d[a*COORD_W +: COORD_W]            = r.org[a];
         d[(AXES+a)*COORD_W +: COORD_W]     = r.inv[a];
         d[(2*AXES+a)*COORD_W +: COORD_W]   = r.lo[a];
         d[(3*AXES+a)*COORD_W +: COORD_W]   = r.hi[a];
      end
      return d;
   endfunction

   function automatic ray_type iso_ray(coord_type o, coord_type i, coord_type l, coord_type h);
      ray_type r;
      for (int a = 0; a < AXES; a++) begin
         r.org[a] = o;
         r.inv[a] = i;
         r.lo[a]  = l;
         r.hi[a]  = h;
      end
      return r;
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      int      c;
      int      e;
      int      off;
      int      span;
      logic    noise;
      noise = ($urandom_range(0, 4) == 0);
      for (int a = 0; a < AXES; a++) begin
         if (noise) begin
            r.org[a] = $urandom;
            r.inv[a] = $urandom;
            r.lo[a]  = $urandom;
            r.hi[a]  = $urandom;
         end else begin
            span = $urandom_range(4, 26);
            c    = $signed($urandom) >>> (31 - span);
            e    = $urandom >> (31 - span);
            off  = $signed($urandom) >>> (30 - span);
            r.org[a] = c + off;
            r.lo[a]  = c - e;
            r.hi[a]  = c + e;
            if ($urandom_range(0, 7) == 0) begin
               r.lo[a] = c + e;
               r.hi[a] = c - e;
            end
            case ($urandom_range(0, 15))
               0: r.inv[a] = '0;
               1: r.inv[a] = $urandom_range(0, 1) ? T_MAX : T_MIN;
               default: begin
                  r.inv[a] = $urandom >> $urandom_range(8, 24);
                  if ((off > 0) ^ ($urandom_range(0, 3) == 0)) r.inv[a] = -r.inv[a];
               end
            endcase
         end
      end
      return r;
   endfunction

   task automatic note_mismatch(string field, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
   endtask

   task automatic check_verdict(logic [RSP_DW-1:0] beat);
      verdict_type want;
      if (verdict_q.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: response beat %h with nothing expected", $time, beat);
         return;
      end
      want = verdict_q.pop_front();
      if (beat[0] !== want.hit) note_mismatch("hit", COORD_W'(want.hit), COORD_W'(beat[0]));
      if (beat[32:1] !== want.t_near) note_mismatch("t_near", want.t_near, beat[32:1]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_run_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_verdict(rsp_tdata);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_run_left == 0) begin
               rx_ready_run = !rx_ready_run;
               if (rx_ready_run)
                  rx_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                            : $urandom_range(1, 20);
               else
                  rx_run_left = $urandom_range(1, 6);
            end
            rx_run_left--;
            rsp_tready <= rx_ready_run;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_ray(ray_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (max_gap == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_gap);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= pack_ray(r);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      verdict_q.push_back(predict_verdict(r, clamp_model));
   endtask

   task automatic pause_sending();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      pause_sending();
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_clamp(logic v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      clamp_model = v;
      @(posedge clock);
   endtask

   task automatic test_directed_clamped();
      ray_type r;
      set_clamp(1'b1);
      send_ray(iso_ray(0, Q_ONE, 2*Q_ONE, 4*Q_ONE));
      send_ray(iso_ray(3*Q_ONE, Q_ONE, 2*Q_ONE, 4*Q_ONE));
      send_ray(iso_ray(5*Q_ONE, Q_ONE, 2*Q_ONE, 4*Q_ONE));
      r = iso_ray(0, Q_ONE, 2*Q_ONE, 4*Q_ONE);
      r.lo[1] = 10*Q_ONE;
      r.hi[1] = 12*Q_ONE;
      send_ray(r);
      r = iso_ray(0, Q_ONE, 2*Q_ONE, 4*Q_ONE);
      r.inv[0] = '0;
      send_ray(r);
      send_ray(iso_ray(3*Q_ONE, 0, 2*Q_ONE, 4*Q_ONE));
      send_ray(iso_ray(0, Q_ONE, 4*Q_ONE, 2*Q_ONE));
      send_ray(iso_ray(0, Q_ONE, 2*Q_ONE, 2*Q_ONE));
      send_ray(iso_ray(4*Q_ONE, Q_ONE, 2*Q_ONE, 4*Q_ONE));
      send_ray(iso_ray(6*Q_ONE, -Q_ONE, 2*Q_ONE, 4*Q_ONE));
      send_ray(iso_ray(0, -1, 1, 3));
      send_ray(iso_ray(0, -1, -3, -1));
      send_ray(iso_ray(T_MIN, T_MAX, T_MAX, T_MAX));
      send_ray(iso_ray(T_MAX, T_MAX, T_MIN, T_MIN));
      send_ray(iso_ray(T_MIN, T_MIN, T_MIN, T_MAX));
      send_ray(iso_ray(0, 0, 0, 0));
      send_ray(iso_ray(-1, -1, -1, -1));
      send_ray(iso_ray(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
      send_ray(iso_ray(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
   endtask

   task automatic test_directed_unclamped();
      set_clamp(1'b0);
      send_ray(iso_ray(3*Q_ONE, Q_ONE, 2*Q_ONE, 4*Q_ONE));
      send_ray(iso_ray(4*Q_ONE, Q_ONE, 2*Q_ONE, 4*Q_ONE));
      send_ray(iso_ray(T_MIN, T_MIN, T_MIN, T_MAX));
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) send_ray(random_ray());
   endtask

   task automatic test_output_backpressure();
      set_clamp(1'b1);
      max_gap = 0;
      hold_requests++;
      repeat (200) send_ray(random_ray());
      max_gap = 5;
   endtask

   task automatic test_drain_pauses();
      for (int round = 0; round < 4; round++) begin
         set_clamp(round[0]);
         repeat (250) send_ray(random_ray());
         pause_sending();
         while (verdict_q.size() != 0) @(posedge clock);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_clamped();
      test_directed_unclamped();
      test_random_traffic(500);
      test_output_backpressure();
      test_drain_pauses();
      wait_drained();
      repeat (12) @(posedge clock);
      mismatches += verdict_q.size();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
